/* hw/rtl/lgm_pkg.sv */
// ----------------------------------------------------------------------------
// lgm_pkg
// Shared types and constants for the largest gap midpoint block: request and
// result payloads, cell chain control and configuration register indexes.
// ----------------------------------------------------------------------------
package lgm_pkg;

   localparam int COORD_W   = 32;
   localparam int TAG_W     = 4;
   localparam int POS_W     = 9;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_BOUND  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_BOUND  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SELECTED_DIM = 2'd2;

   localparam logic signed [COORD_W-1:0] LOWER_BOUND_RESET = 32'sd0;
   localparam logic signed [COORD_W-1:0] UPPER_BOUND_RESET = 32'sd65536;
   localparam logic [TAG_W-1:0]          SELECTED_DIM_RESET = 4'd0;

   typedef struct packed {
      logic signed [COORD_W-1:0] coordinate;
      logic [TAG_W-1:0]          dimension_tag;
      logic                      last_entry;
   } lgm_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] gap_midpoint;
      logic [COORD_W-1:0]        gap_width;
      logic [POS_W-1:0]          gap_position;
      logic                      capacity_overflow;
   } lgm_rsp_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } lgm_ctrl_type;

endpackage

/* hw/rtl/lgm_cell.sv */
// ----------------------------------------------------------------------------
// lgm_cell
// One slot of the sorted chain. Inserts a key in parallel with its neighbors
// or shifts its value down toward the chain head.
// ----------------------------------------------------------------------------
module lgm_cell
   import lgm_pkg::*;
(
   input  logic                      clock,
   input  lgm_ctrl_type              ctrl,
   input  logic signed [COORD_W-1:0] key,
   input  logic signed [COORD_W-1:0] left_val,
   input  logic                      left_gt,
   input  logic                      left_occ,
   input  logic signed [COORD_W-1:0] right_val,
   input  logic                      occ,
   output logic signed [COORD_W-1:0] val,
   output logic                      gt
);

   logic signed [COORD_W-1:0] val_ff;
   logic signed [COORD_W-1:0] val_in;

   assign gt  = occ && (val_ff > key);
   assign val = val_ff;

   always_comb begin
      val_in = val_ff;
      if (ctrl.insert) begin
         if (left_gt) begin
            val_in = left_val;
         end else if (gt || (!occ && left_occ)) begin
            val_in = key;
         end
      end else if (ctrl.shift) begin
         val_in = right_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

/* hw/rtl/lgm_scan.sv */
// ----------------------------------------------------------------------------
// lgm_scan
// Running widest-gap search over the values leaving the chain head, one
// value per cycle; the first strictly widest gap is kept.
// ----------------------------------------------------------------------------
module lgm_scan
   import lgm_pkg::*;
#(
   parameter int IDX_W = 9
)
(
   input  logic                      clock,
   input  logic                      load,
   input  logic                      step,
   input  logic signed [COORD_W-1:0] head,
   output logic [COORD_W-1:0]        best_width,
   output logic [COORD_W-1:0]        best_low,
   output logic [IDX_W-1:0]          best_pos
);

   logic [COORD_W-1:0] prev_ff,  prev_in;
   logic [COORD_W-1:0] bw_ff,    bw_in;
   logic [COORD_W-1:0] blo_ff,   blo_in;
   logic [IDX_W-1:0]   bpos_ff,  bpos_in;
   logic [IDX_W-1:0]   idx_ff,   idx_in;
   logic [COORD_W-1:0] width;

   assign width = COORD_W'(head) - prev_ff;

   always_comb begin
      prev_in = prev_ff;
      bw_in   = bw_ff;
      blo_in  = blo_ff;
      bpos_in = bpos_ff;
      idx_in  = idx_ff;
      if (load) begin
         prev_in = COORD_W'(head);
         bw_in   = '0;
         blo_in  = COORD_W'(head);
         bpos_in = '0;
         idx_in  = '0;
      end else if (step) begin
         prev_in = COORD_W'(head);
         idx_in  = idx_ff + 1'b1;
         if (width > bw_ff) begin
            bw_in   = width;
            blo_in  = prev_ff;
            bpos_in = idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      bw_ff   <= bw_in;
      blo_ff  <= blo_in;
      bpos_ff <= bpos_in;
      idx_ff  <= idx_in;
   end

   assign best_width = bw_ff;
   assign best_low   = blo_ff;
   assign best_pos   = bpos_ff;

endmodule

/* hw/rtl/largest_gap_midpoint.sv */
// A matching request without last_entry is stored by one parallel insert.
// A last_entry request then runs two bound inserts, a head load, one chain
// shift per stored value plus one, and emit, which waits out rsp_stall and registers the response.
// Throughput: 1 request per cycle while filling; the scan of stored_count + 2
// values through the chain head blocks new requests until the response is out.
// Reset: synchronous, clears state, count, overflow flag and response valid, loads bound and dimension defaults.
// ----------------------------------------------------------------------------
// largest_gap_midpoint
// Keeps matching coordinates sorted in a chain of cells and, at the end of a
// set, reports the midpoint, width and position of the widest adjacent gap.
// ----------------------------------------------------------------------------
module largest_gap_midpoint
   import lgm_pkg::*;
#(
   parameter int MAX_SAMPLES = 256
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lgm_req_type           req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lgm_rsp_type           rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COORD_W-1:0]    csr_data
);

   localparam int NCELLS = MAX_SAMPLES + 2;
   localparam int CNT_W  = $clog2(NCELLS + 1);
   localparam int IDX_W  = $clog2(NCELLS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INS_LO = 3'd1;
   localparam logic [2:0] ST_INS_HI = 3'd2;
   localparam logic [2:0] ST_LOAD   = 3'd3;
   localparam logic [2:0] ST_SCAN   = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          rem_ff,   rem_in;
   logic                      ovf_ff,   ovf_in;
   logic signed [COORD_W-1:0] lower_ff, lower_in;
   logic signed [COORD_W-1:0] upper_ff, upper_in;
   logic [TAG_W-1:0]          sel_ff,   sel_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   lgm_rsp_type               rsp_ff,   rsp_in;

   logic                      req_accept;
   logic                      match;
   logic                      has_room;
   logic                      emit_go;
   lgm_ctrl_type              ctrl;
   logic signed [COORD_W-1:0] key;
   logic signed [COORD_W-1:0] cell_val [NCELLS];
   logic                      cell_gt  [NCELLS];
   logic                      cell_occ [NCELLS];
   logic [COORD_W-1:0]        best_width;
   logic [COORD_W-1:0]        best_low;
   logic [IDX_W-1:0]          best_pos;
   logic [IDX_W+POS_W-1:0]    pos_ext;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign match      = (req_payload.dimension_tag == sel_ff);
   assign has_room   = (count_ff < CNT_W'(MAX_SAMPLES));
   assign emit_go    = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready  = 1'b1;

   always_comb begin
      key = req_payload.coordinate;
      case (state_ff)
         ST_INS_LO: key = lower_ff;
         ST_INS_HI: key = upper_ff;
         default:   key = req_payload.coordinate;
      endcase
   end

   assign ctrl.insert = (req_accept && match && has_room) ||
                        (state_ff == ST_INS_LO) || (state_ff == ST_INS_HI);
   assign ctrl.shift  = (state_ff == ST_LOAD) || (state_ff == ST_SCAN);

   for (genvar i = 0; i < NCELLS; i++) begin : g_cell
      logic signed [COORD_W-1:0] left_val;
      logic                      left_gt;
      logic                      left_occ;
      logic signed [COORD_W-1:0] right_val;

      assign cell_occ[i] = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign left_val = key;
         assign left_gt  = 1'b0;
         assign left_occ = 1'b1;
      end else begin : g_body
         assign left_val = cell_val[i-1];
         assign left_gt  = cell_gt[i-1];
         assign left_occ = cell_occ[i-1];
      end

      if (i == NCELLS - 1) begin : g_tail
         assign right_val = cell_val[i];
      end else begin : g_mid
         assign right_val = cell_val[i+1];
      end

      lgm_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .key       (key),
         .left_val  (left_val),
         .left_gt   (left_gt),
         .left_occ  (left_occ),
         .right_val (right_val),
         .occ       (cell_occ[i]),
         .val       (cell_val[i]),
         .gt        (cell_gt[i])
      );
   end

   lgm_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock      (clock),
      .load       (state_ff == ST_LOAD),
      .step       (state_ff == ST_SCAN),
      .head       (cell_val[0]),
      .best_width (best_width),
      .best_low   (best_low),
      .best_pos   (best_pos)
   );

   assign pos_ext = {{POS_W{1'b0}}, best_pos};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (match) begin
                  if (has_room) begin
                     count_in = count_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (req_payload.last_entry) begin
                  state_in = ST_INS_LO;
               end
            end
         end
         ST_INS_LO: begin
            count_in = count_ff + 1'b1;
            state_in = ST_INS_HI;
         end
         ST_INS_HI: begin
            count_in = count_ff + 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rem_in   = count_ff - 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rem_in = rem_ff - 1'b1;
            if (rem_ff == CNT_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in             = 1'b1;
               rsp_in.gap_midpoint      = $signed(best_low + {1'b0, best_width[COORD_W-1:1]});
               rsp_in.gap_width         = best_width;
               rsp_in.gap_position      = pos_ext[POS_W-1:0];
               rsp_in.capacity_overflow = ovf_ff;
               count_in                 = '0;
               ovf_in                   = 1'b0;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      lower_in = lower_ff;
      upper_in = upper_ff;
      sel_in   = sel_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOWER_BOUND:  lower_in = $signed(csr_data);
            CSR_UPPER_BOUND:  upper_in = $signed(csr_data);
            CSR_SELECTED_DIM: sel_in   = csr_data[TAG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         ovf_ff       <= 1'b0;
         lower_ff     <= LOWER_BOUND_RESET;
         upper_ff     <= UPPER_BOUND_RESET;
         sel_ff       <= SELECTED_DIM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         ovf_ff       <= ovf_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NCELLS))
      else $error("chain count beyond cell count");

   a_idle_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (count_ff <= CNT_W'(MAX_SAMPLES)))
      else $error("bounds left in chain while idle");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("response raised outside emit");

   a_bounds_then_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_HI) |=> (state_ff == ST_LOAD))
      else $error("scan load skipped after bound insert");

   a_scan_remaining: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (rem_ff != '0))
      else $error("scan ran past last value");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for largest_gap_midpoint. Coordinate sets are streamed
// in bursts while the result side stalls on its own pattern. A shadow sorted
// store predicts the widest gap of every set, and results are compared field
// by field in order. Bounds and dimension are changed between quiet phases.
// ----------------------------------------------------------------------------
module tb_top
   import lgm_pkg::*;
();

   localparam int MAX_KEPT = 256;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef logic signed [COORD_W-1:0] coord_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   lgm_req_type          req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   lgm_rsp_type          rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COORD_W-1:0]   csr_data = '0;

   lgm_req_type entry_queue[$];
   lgm_rsp_type gap_results_due[$];
   coord_type   kept_coords[$];
   coord_type   lo_bound, hi_bound;
   logic [TAG_W-1:0] sel_dim;
   logic        lost_sample;
   int          err_count = 0;
   int          results_seen = 0;

   coord_type   cfg_lo = LOWER_BOUND_RESET;
   coord_type   cfg_hi = UPPER_BOUND_RESET;
   logic [TAG_W-1:0] cfg_dim = SELECTED_DIM_RESET;
   coord_type   prev_coord = '0;

   int burst_left = 1;
   int gap_left = 0;
   int hold_left = 0;
   int holds_done = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int stall_tick = 0;

   largest_gap_midpoint #(
      .MAX_SAMPLES (MAX_KEPT)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------------
   // prediction and checking
   // ------------------------------------------------------------------------
   function automatic void place_sorted(ref coord_type q[$], input coord_type v);
      int k;
      k = q.size();
      while (k > 0 && q[k-1] > v) k--;
      q.insert(k, v);
   endfunction

   task automatic absorb_entry(input lgm_req_type r);
      coord_type   span[$];
      lgm_rsp_type res;
      longint      w, best_w;
      int          best, i;
      if (r.dimension_tag == sel_dim) begin
         if (kept_coords.size() < MAX_KEPT) place_sorted(kept_coords, r.coordinate);
         else lost_sample = 1'b1;
      end
      if (!r.last_entry) return;
      span = kept_coords;
      place_sorted(span, lo_bound);
      place_sorted(span, hi_bound);
      best = 0;
      best_w = 0;
      for (i = 0; i + 1 < span.size(); i++) begin
         w = longint'(span[i+1]) - longint'(span[i]);
         if (w > best_w) begin
            best_w = w;
            best = i;
         end
      end
      w = longint'(span[best]) + (best_w >>> 1);
      res.gap_midpoint = w[COORD_W-1:0];
      res.gap_width = best_w[COORD_W-1:0];
      res.gap_position = best[POS_W-1:0];
      res.capacity_overflow = lost_sample;
      gap_results_due.push_back(res);
      kept_coords.delete();
      lost_sample = 1'b0;
   endtask

   task automatic flag_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      err_count++;
   endtask

   task automatic compare_result(input lgm_rsp_type got);
      lgm_rsp_type want;
      if (gap_results_due.size() == 0) begin
         flag_mismatch("response with no request due");
         return;
      end
      want = gap_results_due.pop_front();
      if (got.gap_midpoint !== want.gap_midpoint)
         flag_mismatch($sformatf("gap_midpoint got %h want %h",
                                 got.gap_midpoint, want.gap_midpoint));
      if (got.gap_width !== want.gap_width)
         flag_mismatch($sformatf("gap_width got %h want %h",
                                 got.gap_width, want.gap_width));
      if (got.gap_position !== want.gap_position)
         flag_mismatch($sformatf("gap_position got %0d want %0d",
                                 got.gap_position, want.gap_position));
      if (got.capacity_overflow !== want.capacity_overflow)
         flag_mismatch($sformatf("capacity_overflow got %b want %b",
                                 got.capacity_overflow, want.capacity_overflow));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lo_bound = LOWER_BOUND_RESET;
         hi_bound = UPPER_BOUND_RESET;
         sel_dim = SELECTED_DIM_RESET;
         kept_coords.delete();
         lost_sample = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LOWER_BOUND:  lo_bound = csr_data;
               CSR_UPPER_BOUND:  hi_bound = csr_data;
               CSR_SELECTED_DIM: sel_dim = csr_data[TAG_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            compare_result(rsp_payload);
            results_seen++;
         end
         if (req_valid && !req_stall) absorb_entry(req_payload);
      end
   end

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (entry_queue.size() != 0) begin
            req_payload <= entry_queue.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                       : $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // result stall pattern, with long hold-offs to back up the input
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_tick++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (holds_done < 2 && results_seen >= 20 + 150 * holds_done
                      && req_valid) begin
            hold_left = 400;
            holds_done++;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 300);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ((stall_tick % 5) < 2);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic queue_entry(input coord_type c, input logic [TAG_W-1:0] tag,
                              input logic last);
      entry_queue.push_back('{coordinate: c, dimension_tag: tag, last_entry: last});
   endtask

   function automatic coord_type pick_coordinate();
      coord_type c;
      case ($urandom_range(0, 5))
         0: c = $urandom;
         1: c = coord_type'($urandom_range(0, 2000)) - 1000;
         2: c = cfg_lo + coord_type'($urandom_range(0, 4096)) - 2048;
         3: c = cfg_hi + coord_type'($urandom_range(0, 4096)) - 2048;
         4: case ($urandom_range(0, 3))
               0: c = 32'h7FFF_FFFF;
               1: c = 32'h8000_0000;
               2: c = '0;
               default: c = '1;
            endcase
         default: c = prev_coord;
      endcase
      prev_coord = c;
      return c;
   endfunction

   task automatic queue_set(input int n_items, input int match_pct);
      int k;
      logic [TAG_W-1:0] tag;
      for (k = 0; k < n_items; k++) begin
         tag = ($urandom_range(1, 100) <= match_pct) ? cfg_dim
                                                     : TAG_W'($urandom_range(0, 15));
         queue_entry(pick_coordinate(), tag, k == n_items - 1);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [COORD_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input coord_type lo, input coord_type hi,
                             input logic [TAG_W-1:0] dim);
      cfg_lo = lo;
      cfg_hi = hi;
      cfg_dim = dim;
      write_reg(CSR_LOWER_BOUND, lo);
      write_reg(CSR_UPPER_BOUND, hi);
      write_reg(CSR_SELECTED_DIM, {{(COORD_W-TAG_W){1'b0}}, dim});
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (entry_queue.size() != 0 || req_valid || gap_results_due.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int        phase, budget, size_pick, n_items, match_pct;
      coord_type lo, hi;
      logic [TAG_W-1:0] dim;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty set, bounds alone
      queue_entry(32'h0001_2345, 4'd5, 1'b1);
      // coordinate extremes, foreign tag, matching last entry
      queue_entry(32'h7FFF_FFFF, 4'd0, 1'b0);
      queue_entry(32'h8000_0000, 4'd0, 1'b0);
      queue_entry(32'h0000_1234, 4'd15, 1'b0);
      queue_entry(32'h0000_0000, 4'd0, 1'b1);
      // last entry with a foreign tag
      queue_entry(32'd300, 4'd0, 1'b0);
      queue_entry(32'd9, 4'd9, 1'b1);
      wait_idle();

      set_config(32'hFFFF_0000, 32'h0002_0000, 4'd15);
      queue_entry(32'hFFFF_8000, 4'd15, 1'b0);
      queue_entry(32'd5, 4'd3, 1'b0);
      queue_entry(32'h0001_0000, 4'd15, 1'b1);
      wait_idle();

      // every gap zero
      set_config(32'd100, 32'd100, 4'd15);
      queue_entry(32'd100, 4'd15, 1'b0);
      queue_entry(32'd100, 4'd15, 1'b1);
      wait_idle();

      // bounds reversed at the extremes, widest possible gap
      set_config(32'h7FFF_FFFF, 32'h8000_0000, 4'd0);
      write_reg(CSR_UNUSED, 32'hDEAD_BEEF);
      queue_entry(32'd55, 4'd1, 1'b1);
      wait_idle();

      // equal gaps, the first one wins
      set_config(32'd0, 32'd300, 4'd0);
      queue_entry(32'd200, 4'd0, 1'b0);
      queue_entry(32'd100, 4'd0, 1'b1);
      queue_entry(32'd7, 4'd15, 1'b1);
      wait_idle();

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; dim = 4'd0; end
            1: begin
               lo = $urandom;
               hi = lo + coord_type'($urandom_range(0, 65535));
               dim = TAG_W'($urandom_range(0, 15));
            end
            2: begin
               hi = $urandom;
               lo = hi + coord_type'($urandom_range(0, 1 << 20));
               dim = TAG_W'($urandom_range(0, 15));
            end
            3: begin lo = LOWER_BOUND_RESET; hi = UPPER_BOUND_RESET; dim = 4'd15; end
            default: begin
               lo = $urandom;
               hi = $urandom;
               dim = TAG_W'($urandom_range(0, 15));
            end
         endcase
         set_config(lo, hi, dim);
         if (phase % 3 == 1) write_reg(CSR_UNUSED, $urandom);

         budget = 0;
         while (budget < 160) begin
            size_pick = $urandom_range(0, 19);
            if (size_pick < 16) n_items = $urandom_range(1, 10);
            else if (size_pick < 19) n_items = $urandom_range(11, 40);
            else n_items = $urandom_range(41, 120);
            match_pct = ($urandom_range(0, 9) == 0) ? 0 : 75;
            queue_set(n_items, match_pct);
            budget += n_items;
         end
         // fill the store exactly, then past its end
         if (phase == 2) queue_set(MAX_KEPT, 100);
         if (phase == 5) queue_set(MAX_KEPT + $urandom_range(1, 8), 100);
         wait_idle();
      end

      repeat (300) @(posedge clock);
      if (gap_results_due.size() != 0) flag_mismatch("responses still due at end");
      if (err_count == 0) begin
         $display("[largest_gap_midpoint] OK");
      end else begin
         $display("[largest_gap_midpoint] ERROR");
      end
      $finish;
   end

   initial begin
      #7200000;
      $display("[largest_gap_midpoint] ERROR");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/lgm_pkg.sv
hw/rtl/lgm_cell.sv
hw/rtl/lgm_scan.sv
hw/rtl/largest_gap_midpoint.sv
tb/sv/tb_top.sv
